@@ rtl/dqpb_pkg.sv @@
// shared types and constants for the dns query message encoder
`timescale 1ns / 1ps
`default_nettype none
package dqpb_pkg;

	localparam int LEN_W = 6;
	localparam int CNT_W = 6;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_CHAR  = 2'd1;
	localparam logic [1:0] CMD_END   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_ID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLAGS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECURSION = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QTYPE     = 2'd3;

	localparam logic [7:0]  CHAR_DOT     = 8'h2E;
	localparam logic [15:0] QTYPE_RESET  = 16'd1;
	localparam logic [15:0] QCLASS_IN    = 16'd1;
	localparam logic [15:0] QDCOUNT      = 16'd1;
	localparam logic [CNT_W-1:0] HDR_LAST  = 6'd11;
	localparam logic [CNT_W-1:0] TAIL_LAST = 6'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] name_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       label_overflow;
	} out_item_t;

	typedef struct packed {
		logic [15:0] query_id;
		logic [15:0] header_flags;
		logic        recursion_desired;
		logic [15:0] query_type;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_START,
		OP_FLUSH,
		OP_END
	} op_t;

	// one job for the back end
	typedef struct packed {
		op_t              op;
		logic [LEN_W-1:0] len;
		logic             ovf;
		logic             bank;
	} job_t;

	// label buffer bank handed back by the back end
	typedef struct packed {
		logic valid;
		logic bank;
	} release_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_HDR,
		B_LEN,
		B_RD,
		B_CHR,
		B_TAIL
	} back_state_t;

	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input cfg_t cfg);
		logic [15:0] flags;
		logic [7:0]  b;
		begin
			flags = {cfg.header_flags[15:9], cfg.recursion_desired, cfg.header_flags[7:0]};
			unique case (idx)
				4'd0: b = cfg.query_id[15:8];
				4'd1: b = cfg.query_id[7:0];
				4'd2: b = flags[15:8];
				4'd3: b = flags[7:0];
				4'd4: b = QDCOUNT[15:8];
				4'd5: b = QDCOUNT[7:0];
				default: b = 8'd0;
			endcase
			return b;
		end
	endfunction

	function automatic logic [7:0] tail_byte(input logic [2:0] idx, input cfg_t cfg);
		logic [7:0] b;
		begin
			unique case (idx)
				3'd1: b = cfg.query_type[15:8];
				3'd2: b = cfg.query_type[7:0];
				3'd3: b = QCLASS_IN[15:8];
				3'd4: b = QCLASS_IN[7:0];
				default: b = 8'd0;
			endcase
			return b;
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/dqpb_ram.sv @@
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module dqpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/dqpb_front.sv @@
// front end: takes commands, buffers label characters, queues jobs
`timescale 1ns / 1ps
`default_nettype none
module dqpb_front #(
	parameter int LABEL_MAX = 32,
	parameter int IDX_W = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire dqpb_pkg::in_item_t in_data,
	output      logic               job_valid,
	input  wire logic               job_ready,
	output      dqpb_pkg::job_t     job,
	input  wire dqpb_pkg::release_t rel,
	output      logic               ram_we,
	output      logic [IDX_W:0]     ram_waddr,
	output      logic [7:0]         ram_wdata
);
	import dqpb_pkg::*;

	localparam logic [LEN_W-1:0] LMAX = LEN_W'(LABEL_MAX);

	logic [LEN_W-1:0] len_q;
	logic             ovf_q;
	logic             bank_q;
	logic [1:0]       busy_q;

	logic is_dot;
	logic accept;
	logic push;
	logic [LEN_W-1:0] len_n;
	logic             ovf_n;
	logic             bank_n;
	logic [1:0]       busy_n;

	assign is_dot = in_data.name_char == CHAR_DOT;

	always_comb begin
		in_ready  = 1'b1;
		push      = 1'b0;
		job.op    = OP_START;
		job.len   = len_q;
		job.ovf   = ovf_q;
		job.bank  = bank_q;
		ram_we    = 1'b0;
		ram_waddr = {bank_q, len_q[IDX_W-1:0]};
		ram_wdata = in_data.name_char;
		len_n     = len_q;
		ovf_n     = ovf_q;
		bank_n    = bank_q;
		busy_n    = busy_q;
		if (rel.valid) begin
			busy_n[rel.bank] = 1'b0;
		end
		unique case (in_data.command)
			CMD_START: begin
				in_ready = job_ready;
			end
			CMD_CHAR: begin
				in_ready = is_dot ? (job_ready && !busy_q[bank_q]) : !busy_q[bank_q];
			end
			CMD_END: begin
				in_ready = job_ready && !busy_q[bank_q];
			end
			default: begin
				in_ready = 1'b1;
			end
		endcase
		accept = in_valid && in_ready;
		if (accept) begin
			unique case (in_data.command)
				CMD_START: begin
					push  = 1'b1;
					len_n = '0;
					ovf_n = 1'b0;
				end
				CMD_CHAR: begin
					if (is_dot) begin
						push   = 1'b1;
						job.op = OP_FLUSH;
					end else if (len_q < LMAX) begin
						ram_we = 1'b1;
						len_n  = len_q + LEN_W'(1);
					end else begin
						ovf_n = 1'b1;
					end
				end
				CMD_END: begin
					push   = 1'b1;
					job.op = OP_END;
				end
				default: begin
				end
			endcase
			// a queued label keeps its bank until the back end has read it
			if (push && job.op != OP_START) begin
				len_n = '0;
				ovf_n = 1'b0;
				if (len_q != '0) begin
					busy_n[bank_q] = 1'b1;
					bank_n         = !bank_q;
				end
			end
		end
	end

	assign job_valid = push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			ovf_q  <= 1'b0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			len_q  <= len_n;
			ovf_q  <= ovf_n;
			bank_q <= bank_n;
			busy_q <= busy_n;
		end
	end
endmodule
`default_nettype wire

@@ rtl/dqpb_queue.sv @@
// two-entry job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module dqpb_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output      logic           push_ready,
	input  wire dqpb_pkg::job_t push_data,
	input  wire logic           pop,
	output      logic           pop_valid,
	output      dqpb_pkg::job_t pop_data
);
	import dqpb_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/dqpb_back.sv @@
// back end: turns queued jobs into message bytes through an output register
`timescale 1ns / 1ps
`default_nettype none
module dqpb_back #(
	parameter int IDX_W = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire dqpb_pkg::cfg_t      cfg,
	input  wire logic                job_valid,
	output      logic                job_pop,
	input  wire dqpb_pkg::job_t      job,
	output      dqpb_pkg::release_t  rel,
	output      logic                ram_re,
	output      logic [IDX_W:0]      ram_raddr,
	input  wire logic [7:0]          ram_rdata,
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      dqpb_pkg::out_item_t out_data
);
	import dqpb_pkg::*;

	back_state_t      state_q, state_n;
	job_t             job_q, job_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             out_valid_q;
	out_item_t        out_q;

	logic      slot_free;
	logic      emit;
	out_item_t emit_item;
	logic [CNT_W-1:0] last_idx;

	assign slot_free = !out_valid_q || out_ready;
	assign last_idx  = CNT_W'(job_q.len) - CNT_W'(1);

	always_comb begin
		state_n   = state_q;
		job_n     = job_q;
		cnt_n     = cnt_q;
		job_pop   = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = job_q.bank;
		ram_re    = 1'b0;
		ram_raddr = {job_q.bank, cnt_q[IDX_W-1:0]};
		emit      = 1'b0;
		emit_item = '0;
		unique case (state_q)
			B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					job_n   = job;
					cnt_n   = '0;
					unique case (job.op)
						OP_START: state_n = B_HDR;
						OP_FLUSH: state_n = B_LEN;
						OP_END:   state_n = (job.len != '0) ? B_LEN : B_TAIL;
						default:  state_n = B_IDLE;
					endcase
				end
			end
			B_HDR: begin
				emit_item.out_byte = hdr_byte(cnt_q[3:0], cfg);
				emit_item.run_last = cnt_q == HDR_LAST;
				if (slot_free) begin
					emit  = 1'b1;
					cnt_n = cnt_q + CNT_W'(1);
					if (cnt_q == HDR_LAST) begin
						state_n = B_IDLE;
					end
				end
			end
			B_LEN: begin
				emit_item.out_byte       = 8'(job_q.len);
				emit_item.label_overflow = job_q.ovf;
				// an empty label on a dot is a lone zero length byte
				emit_item.run_last       = job_q.op == OP_FLUSH && job_q.len == '0;
				if (slot_free) begin
					emit    = 1'b1;
					cnt_n   = '0;
					state_n = (job_q.len == '0) ? B_IDLE : B_RD;
				end
			end
			B_RD: begin
				ram_re  = 1'b1;
				state_n = B_CHR;
			end
			B_CHR: begin
				emit_item.out_byte       = ram_rdata;
				emit_item.label_overflow = job_q.ovf;
				emit_item.run_last       = job_q.op == OP_FLUSH && cnt_q == last_idx;
				if (slot_free) begin
					emit  = 1'b1;
					cnt_n = cnt_q + CNT_W'(1);
					if (cnt_q == last_idx) begin
						rel.valid = 1'b1;
						cnt_n     = '0;
						state_n   = (job_q.op == OP_FLUSH) ? B_IDLE : B_TAIL;
					end else begin
						state_n = B_RD;
					end
				end
			end
			B_TAIL: begin
				emit_item.out_byte = tail_byte(cnt_q[2:0], cfg);
				emit_item.run_last = cnt_q == TAIL_LAST;
				if (slot_free) begin
					emit  = 1'b1;
					cnt_n = cnt_q + CNT_W'(1);
					if (cnt_q == TAIL_LAST) begin
						state_n = B_IDLE;
					end
				end
			end
			default: begin
				state_n = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			cnt_q   <= cnt_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		job_q <= job_n;
		if (emit) begin
			out_q <= emit_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

@@ rtl/dns_query_packet_builder_unit.sv @@
// top level of the dns query message encoder
// a job is popped from the queue in the idle state; its bytes are emitted through the output register
// throughput: header and tail bytes 1 per cycle while the output is not stalled, label bytes read
// from the ram, then loaded into the output register; a new job is taken from the two-entry queue only when idle
// name characters are taken 1 per cycle while their label bank is free
// reset: arst_n clears control state and config; label ram needs no clearing
`timescale 1ns / 1ps
`default_nettype none
module dns_query_packet_builder_unit #(
	parameter int LABEL_MAX = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_ready,
	input  wire dqpb_pkg::in_item_t                  in_data,
	output      logic                                out_valid,
	input  wire logic                                out_ready,
	output      dqpb_pkg::out_item_t                 out_data,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [dqpb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [15:0]                         cfg_data
);
	import dqpb_pkg::*;

	localparam int IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
	localparam int RAM_DEPTH = 2 << IDX_W;

	cfg_t     cfg_q;
	job_t     push_job;
	job_t     pop_job;
	logic     push_valid;
	logic     push_ready;
	logic     pop_valid;
	logic     pop;
	release_t rel;
	logic             ram_we;
	logic [IDX_W:0]   ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [IDX_W:0]   ram_raddr;
	logic [7:0]       ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.query_id          <= '0;
			cfg_q.header_flags      <= '0;
			cfg_q.recursion_desired <= 1'b0;
			cfg_q.query_type        <= QTYPE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUERY_ID:  cfg_q.query_id          <= cfg_data;
				REG_FLAGS:     cfg_q.header_flags      <= cfg_data;
				REG_RECURSION: cfg_q.recursion_desired <= cfg_data[0];
				REG_QTYPE:     cfg_q.query_type        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	dqpb_front #(
		.LABEL_MAX(LABEL_MAX),
		.IDX_W(IDX_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.job_valid(push_valid),
		.job_ready(push_ready),
		.job      (push_job),
		.rel      (rel),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata)
	);

	dqpb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_ready(push_ready),
		.push_data (push_job),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_job)
	);

	dqpb_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_label_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	dqpb_back #(
		.IDX_W(IDX_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.job_valid(pop_valid),
		.job_pop  (pop),
		.job      (pop_job),
		.rel      (rel),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the dns query message encoder
`timescale 1ns / 1ps
module tb_top;
	import dqpb_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int LABEL_MAX = 32;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS = 12;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [15:0] RD_MASK = 16'h0100;
	localparam logic [15:0] ZERO_COUNT = 16'h0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	dns_query_packet_builder_unit #(
		.LABEL_MAX(LABEL_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// mirror of the encoder state and registers
	logic [7:0] lbl_buf [LABEL_MAX];
	logic [LEN_W-1:0] lbl_len = '0;
	logic lbl_cut = 1'b0;
	cfg_t cfg_mirror = '{query_id: 16'h0, header_flags: 16'h0, recursion_desired: 1'b0,
		query_type: QTYPE_RESET};

	in_item_t cmd_queue [$];
	out_item_t exp_bytes [$];
	out_item_t step_bytes [$];
	out_item_t want;

	int queued_cnt = 0;
	int offer_cnt = 0;
	int n_items = 0;
	int n_bytes = 0;
	int n_cfg = 0;
	int n_cut = 0;
	int err_cnt = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int hold_reqs = 0;
	int holds_done = 0;
	int hold_left = 0;
	bit no_idle = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// any byte except the label separator
	function automatic logic [7:0] label_char();
		logic [7:0] c;
		c = rand_byte();
		if (c == CHAR_DOT)
			c = c ^ 8'h01;
		return c;
	endfunction

	task automatic push_out(input logic [7:0] b, input logic ovf);
		out_item_t r;
		r.out_byte = b;
		r.run_last = 1'b0;
		r.label_overflow = ovf;
		step_bytes.insert(step_bytes.size(), r);
	endtask

	task automatic push_word(input logic [15:0] w);
		push_out(w[15:8], 1'b0);
		push_out(w[7:0], 1'b0);
	endtask

	task automatic flush_label();
		int i;
		push_out({2'b00, lbl_len}, lbl_cut);
		for (i = 0; i < lbl_len; i++)
			push_out(lbl_buf[i], lbl_cut);
		if (lbl_cut)
			n_cut++;
		lbl_len = '0;
		lbl_cut = 1'b0;
	endtask

	// expected message bytes for one accepted command
	task automatic encode_command(input in_item_t it);
		logic [15:0] flags;
		step_bytes.delete();
		case (it.command)
			CMD_START: begin
				flags = cfg_mirror.header_flags & ~RD_MASK;
				if (cfg_mirror.recursion_desired)
					flags = flags | RD_MASK;
				lbl_len = '0;
				lbl_cut = 1'b0;
				push_word(cfg_mirror.query_id);
				push_word(flags);
				push_word(QDCOUNT);
				push_word(ZERO_COUNT);
				push_word(ZERO_COUNT);
				push_word(ZERO_COUNT);
			end
			CMD_CHAR: begin
				if (it.name_char == CHAR_DOT) begin
					flush_label();
				end else if (lbl_len < LABEL_MAX) begin
					lbl_buf[lbl_len] = it.name_char;
					lbl_len++;
				end else begin
					lbl_cut = 1'b1;
				end
			end
			CMD_END: begin
				if (lbl_len != 0)
					flush_label();
				push_out(8'h00, 1'b0);
				push_word(cfg_mirror.query_type);
				push_word(QCLASS_IN);
			end
			default: begin
			end
		endcase
		if (step_bytes.size() != 0)
			step_bytes[step_bytes.size() - 1].run_last = 1'b1;
		foreach (step_bytes[i])
			exp_bytes.insert(exp_bytes.size(), step_bytes[i]);
	endtask

	task automatic queue_cmd(input logic [1:0] cmd, input logic [7:0] ch);
		in_item_t it;
		it.command = cmd;
		it.name_char = ch;
		cmd_queue.insert(cmd_queue.size(), it);
		queued_cnt++;
	endtask

	// one query with random labels; some are broken on purpose
	task automatic queue_random_query(input bit force_long);
		int nlab;
		int len;
		int r;
		bit broken;
		broken = force_long ? 1'b0 : ($urandom_range(0, 9) == 0);
		if (!broken || $urandom_range(0, 1) == 0)
			queue_cmd(CMD_START, rand_byte());
		nlab = force_long ? $urandom_range(1, 2) : $urandom_range(1, 4);
		for (int i = 0; i < nlab; i++) begin
			r = $urandom_range(0, 99);
			if (force_long && i == 0)
				len = $urandom_range(LABEL_MAX + 1, LABEL_MAX + 3);
			else if (r < 70)
				len = $urandom_range(1, 6);
			else if (r < 85)
				len = 0;
			else if (r < 95)
				len = $urandom_range(7, LABEL_MAX - 1);
			else
				len = $urandom_range(LABEL_MAX, LABEL_MAX + 3);
			for (int j = 0; j < len; j++) begin
				queue_cmd(CMD_CHAR, label_char());
				if (broken && $urandom_range(0, 19) == 0)
					queue_cmd($urandom_range(0, 1) ? CMD_START : CMD_UNUSED, rand_byte());
			end
			// last label is sometimes left pending for the end command
			if (i != nlab - 1 || $urandom_range(0, 3) == 0)
				queue_cmd(CMD_CHAR, CHAR_DOT);
		end
		queue_cmd(CMD_END, rand_byte());
		if (broken && $urandom_range(0, 1) == 0)
			queue_cmd(CMD_END, rand_byte());
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (n_items != queued_cnt || exp_bytes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_QUERY_ID: cfg_mirror.query_id = val;
			REG_FLAGS: cfg_mirror.header_flags = val;
			REG_RECURSION: cfg_mirror.recursion_desired = val[0];
			REG_QTYPE: cfg_mirror.query_type = val;
			default: begin
			end
		endcase
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [15:0] id, input logic [15:0] flags,
		input logic rd, input logic [15:0] qtype);
		cfg_write(REG_QUERY_ID, id);
		cfg_write(REG_FLAGS, flags);
		cfg_write(REG_RECURSION, {15'd0, rd});
		cfg_write(REG_QTYPE, qtype);
	endtask

	// sender: a new command only once the previous one has been transferred
	always @(negedge clk) begin
		if (arst_n && (!in_valid || n_items == offer_cnt)) begin
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				in_data <= cmd_queue.pop_front();
				in_valid <= 1'b1;
				offer_cnt++;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver with random stalls and an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_reqs != holds_done) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else if (recv_gap != 0) begin
			recv_gap--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (exp_bytes.size() == 0) begin
				$error("unexpected message byte %02h", out_data.out_byte);
				err_cnt++;
			end else begin
				want = exp_bytes.pop_front();
				n_bytes++;
				if (out_data.out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
					err_cnt++;
				end
				if (out_data.run_last !== want.run_last) begin
					$error("run_last: expected %0b, got %0b", want.run_last, out_data.run_last);
					err_cnt++;
				end
				if (out_data.label_overflow !== want.label_overflow) begin
					$error("label_overflow: expected %0b, got %0b", want.label_overflow,
						out_data.label_overflow);
					err_cnt++;
				end
			end
		end
		if (arst_n && in_valid && in_ready) begin
			encode_command(in_data);
			n_items++;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset register values, label corner cases
		queue_cmd(CMD_START, 8'hFF);
		queue_cmd(CMD_CHAR, 8'h00);
		queue_cmd(CMD_CHAR, 8'hFF);
		queue_cmd(CMD_CHAR, CHAR_DOT);
		queue_cmd(CMD_CHAR, CHAR_DOT);
		queue_cmd(CMD_CHAR, 8'h78);
		queue_cmd(CMD_END, 8'h00);
		queue_cmd(CMD_END, 8'hFF);
		queue_cmd(CMD_UNUSED, 8'hFF);
		queue_cmd(CMD_CHAR, 8'h71);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_END, 8'h00);
		wait_idle();

		// all-ones registers, recursion bit cleared out of the flags
		set_config(16'hFFFF, 16'hFFFF, 1'b0, 16'hFFFF);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_CHAR, 8'h80);
		queue_cmd(CMD_CHAR, 8'h7F);
		queue_cmd(CMD_END, 8'h00);
		wait_idle();

		// all-zero registers, recursion bit set
		set_config(16'h0000, 16'h0000, 1'b1, 16'h0000);
		queue_cmd(CMD_START, 8'h00);
		queue_cmd(CMD_CHAR, CHAR_DOT);
		queue_cmd(CMD_END, 8'h00);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
			no_idle = (ph == 1);
			begin
				int start_cnt;
				start_cnt = queued_cnt;
				if (ph == 2) begin
					// stall the output while a long query keeps coming in
					hold_reqs++;
					queue_random_query(1'b1);
				end
				while (queued_cnt - start_cnt < PHASE_ITEMS) begin
					if ($urandom_range(0, 9) == 0)
						queue_cmd(CMD_UNUSED, rand_byte());
					queue_random_query(1'b0);
				end
			end
			wait_idle();
		end
		no_idle = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d commands and %0d register writes over %0d setups",
			n_items, n_cfg, RANDOM_PHASES + 3);
		$display("checked %0d message bytes; %0d labels were cut to the maximum length",
			n_bytes, n_cut);
		if (err_cnt == 0 && exp_bytes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
